/* rtl/core/mdtc_pkg.sv */
`timescale 1ns / 1ps

package mdtc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  localparam int ADDR_W = 16;
  localparam int TID_W = 8;
  localparam int SEC_W = 32;
  localparam int TMO_W = 8;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 8'd10;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_TICK   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TID_W-1:0]  tid;
  } entry_t;

  typedef struct packed {
    logic tick;
    logic new_entry;
  } tmr_ctl_t;

endpackage

/* rtl/core/mesh_duplicate_tid_cache_core.sv */
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// s_        in   s_tvalid / s_tready            s_tdata {tid, src_addr}, s_tuser func
// m_        out  m_tvalid / m_tready            m_tdata {7'b0, duplicate}
// apb       in   psel, penable, pwrite, pready  timeout_seconds at byte address 0
//
// Lookup and insert read each entry from the entry RAM in turn, compare each registered
// read word, then pass through a finish state. A tick or an unused func code is taken
// in the idle state. Reset is synchronous and clears all valid bits at once, so no
// clearing pass is needed. A lookup result waits in the finish state while the output
// register is full and not being drained.

module mesh_duplicate_tid_cache_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // [15:0] src_addr, [23:16] tid
  input  logic [1:0]                     s_tuser,   // [1:0] func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [0] duplicate, [7:1] zero
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mdtc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mdtc_pkg::PDATA_W-1:0]   pwdata,
  output logic [mdtc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import mdtc_pkg::*;

  logic [TMO_W-1:0] timeout;
  logic             reg_wr;
  logic             expire;
  tmr_ctl_t         tmr_ctl;
  logic             res_valid;
  logic             res_ready;
  logic             res_dup;
  logic             dup;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1:2] == REG_TIMEOUT) ? PDATA_W'(timeout) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RST;
    end else if (reg_wr && paddr[PADDR_W-1:2] == REG_TIMEOUT) begin
      timeout <= pwdata[TMO_W-1:0];
    end
  end

  mdtc_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (func_t'(s_tuser)),
    .in_addr  (s_tdata[ADDR_W-1:0]),
    .in_tid   (s_tdata[ADDR_W+TID_W-1:ADDR_W]),
    .expire   (expire),
    .tmr_ctl  (tmr_ctl),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_dup  (res_dup)
  );

  mdtc_timer u_timer (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tmr_ctl),
    .timeout(timeout),
    .expire (expire)
  );

  // output word register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      dup <= res_dup;
    end
  end

  assign m_tdata = {7'b0, dup};

  a_res_has_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!m_tvalid || m_tready))
    else $error("result issued while output register is occupied");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == FN_LOOKUP || s_tuser == FN_INSERT))
      |=> !s_tready)
    else $error("block took a new word during a table scan");

  a_no_new_on_expire: assert property (@(posedge clk) disable iff (rst)
    !(tmr_ctl.new_entry && expire))
    else $error("new entry and table clear in the same cycle");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

endmodule

/* rtl/core/mdtc_ram.sv */
`timescale 1ns / 1ps

module mdtc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mdtc_timer.sv */
`timescale 1ns / 1ps

module mdtc_timer (
  input  logic                  clk,
  input  logic                  rst,
  input  mdtc_pkg::tmr_ctl_t    ctl,
  input  logic [mdtc_pkg::TMO_W-1:0] timeout,
  output logic                  expire
);
  import mdtc_pkg::*;

  // seconds since the last new entry or expiry; same as now - last_event mod 2^32
  logic [SEC_W-1:0] elapsed;
  logic [SEC_W-1:0] elapsed_inc;

  assign elapsed_inc = elapsed + SEC_W'(1);
  assign expire = ctl.tick && (elapsed_inc > SEC_W'(timeout));

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (ctl.new_entry || expire) begin
      elapsed <= '0;
    end else if (ctl.tick) begin
      elapsed <= elapsed_inc;
    end
  end

endmodule

/* rtl/core/mdtc_scan.sv */
`timescale 1ns / 1ps

module mdtc_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mdtc_pkg::func_t             in_func,
  input  logic [mdtc_pkg::ADDR_W-1:0] in_addr,
  input  logic [mdtc_pkg::TID_W-1:0]  in_tid,
  input  logic                        expire,
  output mdtc_pkg::tmr_ctl_t          tmr_ctl,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        res_dup
);
  import mdtc_pkg::*;

  st_t               state;
  st_t               state_next;
  func_t             op_func;
  logic [ADDR_W-1:0] op_addr;
  logic [TID_W-1:0]  op_tid;
  logic [IDX_W-1:0]  idx;
  logic              issuing;
  logic              chk_vld;
  logic [IDX_W-1:0]  chk_idx;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]  slot;
  logic              accept;
  logic              start;
  logic              hit;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  entry_t            rdata;

  mdtc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign start = accept && (in_func == FN_LOOKUP || in_func == FN_INSERT);

  // inserts match on address only, lookups need the tid too
  assign hit = chk_vld && valid[chk_idx] && (rdata.addr == op_addr) &&
               ((op_func == FN_INSERT) || (rdata.tid == op_tid));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_vld && chk_idx == IDX_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (op_func == FN_INSERT || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    res_valid = 1'b0;
    case (state)
      ST_FINISH: begin
        we = (op_func == FN_INSERT);
        res_valid = (op_func == FN_LOOKUP) && res_ready;
      end
      default: begin
        we = 1'b0;
        res_valid = 1'b0;
      end
    endcase
  end

  assign waddr = found ? found_idx : slot;
  assign wdata = '{addr: op_addr, tid: op_tid};
  assign res_dup = found;
  assign tmr_ctl.tick = accept && (in_func == FN_TICK);
  assign tmr_ctl.new_entry = we && !found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issuing <= 1'b0;
      chk_vld <= 1'b0;
      found <= 1'b0;
      valid <= '0;
      slot <= '0;
    end else begin
      state <= state_next;
      chk_vld <= issuing;
      if (start) begin
        issuing <= 1'b1;
        found <= 1'b0;
      end else if (issuing && idx == IDX_LAST) begin
        issuing <= 1'b0;
      end
      if (hit && !found) begin
        found <= 1'b1;
      end
      if (expire) begin
        valid <= '0;
        slot <= '0;
      end else if (we && !found) begin
        valid[slot] <= 1'b1;
        slot <= (slot == IDX_LAST) ? '0 : slot + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_func <= in_func;
      op_addr <= in_addr;
      op_tid <= in_tid;
      idx <= '0;
    end else if (issuing && idx != IDX_LAST) begin
      idx <= idx + IDX_W'(1);
    end
    chk_idx <= idx;
    if (hit && !found) begin
      found_idx <= chk_idx;
    end
  end

endmodule
